[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL modules.
// Each macro expects signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/crcpcs_pkg.sv]
// Types, codes and the CRC-16 byte update for the CRC packet checker/splitter.
// No dependencies.
package crcpcs_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [2:0] ROLE_HEADER = 3'd0;
   localparam logic [2:0] ROLE_TOPLEN = 3'd1;
   localparam logic [2:0] ROLE_TOPIC  = 3'd2;
   localparam logic [2:0] ROLE_DATA   = 3'd3;
   localparam logic [2:0] ROLE_STATUS = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_SHORT    = 3'd1;
   localparam logic [2:0] ST_CRC      = 3'd2;
   localparam logic [2:0] ST_TOPIC    = 3'd3;
   localparam logic [2:0] ST_OVERSIZE = 3'd4;

   localparam logic CSR_START_OFFSET = 1'b0;
   localparam logic CSR_MIN_LENGTH   = 1'b1;

   localparam logic [7:0] START_OFFSET_RESET = 8'd0;
   localparam logic [7:0] MIN_LENGTH_RESET   = 8'd3;

   // Two trailing CRC bytes per packet.
   localparam int CRC_BYTES = 2;

   typedef struct packed {
      logic [7:0] start_offset;
      logic [7:0] min_length;
   } cfg_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] role;
      logic [2:0] status;
      logic       end_of_run;
   } item_type;

   typedef struct packed {
      logic     byte_valid;
      logic     status_valid;
      item_type byte_item;
      item_type status_item;
   } core_out_type;

   // CRC-16/CCITT-FALSE update by one byte, MSB first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[hw/rtl/crcpcs_core.sv]
// Per-byte packet state: CRC, position, two-byte hold-back, role tagging, status.
// Depends on crcpcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module crcpcs_core #(
   parameter int MAX_PACKET_BYTES = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  crcpcs_pkg::cfg_type      cfg,
   input  logic                     fire,
   input  logic [7:0]               data_byte,
   input  logic                     final_byte,
   output crcpcs_pkg::core_out_type core_out
);
   import crcpcs_pkg::*;

   localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
   localparam int CMP_W = (POS_W + 1 > 10) ? POS_W + 1 : 10;
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);

   logic [15:0]      crc_ff, crc_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       dly0_ff, dly0_in, dly1_ff, dly1_in;
   logic [7:0]       tlen_ff, tlen_in;
   logic             over_ff, over_in;

   logic             at_max, byte_rel;
   logic [CMP_W-1:0] q, so, n, topic_end, topic_end_new;
   logic [2:0]       role, st;
   logic [7:0]       tlen_new;
   logic [15:0]      crc_new, sent;
   logic             over_new;

   always_comb begin
      at_max   = pos_ff >= POS_MAX;
      byte_rel = pos_ff >= POS_W'(CRC_BYTES);
      q        = CMP_W'(pos_ff) - CMP_W'(CRC_BYTES);
      so       = CMP_W'(cfg.start_offset);
      topic_end = so + CMP_W'(tlen_ff);
      over_new = over_ff | at_max;

      // Released byte classification; a packet past its size limit is all data.
      if (over_ff) begin
         role = ROLE_DATA;
      end else if (q < so) begin
         role = ROLE_HEADER;
      end else if (q == so) begin
         role = ROLE_TOPLEN;
      end else if (q <= topic_end) begin
         role = ROLE_TOPIC;
      end else begin
         role = ROLE_DATA;
      end

      tlen_new = (byte_rel && role == ROLE_TOPLEN) ? dly0_ff : tlen_ff;
      crc_new  = byte_rel ? crc_byte(crc_ff, dly0_ff) : crc_ff;
      sent     = {dly1_ff, data_byte};
      n        = CMP_W'(pos_ff) + CMP_W'(1);
      topic_end_new = so + CMP_W'(1) + CMP_W'(tlen_new);

      if (!over_new && (n < CMP_W'(cfg.min_length) || n < CMP_W'(CRC_BYTES))) begin
         st = ST_SHORT;
      end else if (sent != crc_new) begin
         st = ST_CRC;
      end else if (so + CMP_W'(CRC_BYTES) >= n ||
                   topic_end_new > n - CMP_W'(CRC_BYTES)) begin
         st = ST_TOPIC;
      end else if (over_new) begin
         st = ST_OVERSIZE;
      end else begin
         st = ST_OK;
      end

      core_out.byte_valid             = byte_rel;
      core_out.byte_item.out_byte     = dly0_ff;
      core_out.byte_item.role         = role;
      core_out.byte_item.status       = ST_OK;
      core_out.byte_item.end_of_run   = 1'b0;
      core_out.status_valid           = final_byte;
      core_out.status_item.out_byte   = 8'h00;
      core_out.status_item.role       = ROLE_STATUS;
      core_out.status_item.status     = st;
      core_out.status_item.end_of_run = 1'b1;

      crc_in  = crc_ff;
      pos_in  = pos_ff;
      dly0_in = dly0_ff;
      dly1_in = dly1_ff;
      tlen_in = tlen_ff;
      over_in = over_ff;
      if (fire) begin
         dly0_in = dly1_ff;
         dly1_in = data_byte;
         if (final_byte) begin
            crc_in  = CRC_INIT;
            pos_in  = '0;
            tlen_in = 8'h00;
            over_in = 1'b0;
         end else begin
            crc_in  = crc_new;
            pos_in  = at_max ? pos_ff : pos_ff + POS_W'(1);
            tlen_in = tlen_new;
            over_in = over_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CRC_INIT;
         pos_ff  <= '0;
         tlen_ff <= 8'h00;
         over_ff <= 1'b0;
      end else begin
         crc_ff  <= crc_in;
         pos_ff  <= pos_in;
         tlen_ff <= tlen_in;
         over_ff <= over_in;
      end
   end

   // Hold-back bytes are only read once two bytes of the packet have arrived.
   always_ff @(posedge clock) begin
      dly0_ff <= dly0_in;
      dly1_ff <= dly1_in;
   end

   `ASSERT_ALWAYS(a_pos_bound, pos_ff <= POS_MAX, "byte position past its limit")
   `ASSERT_IMPLY(a_over_sat, over_ff, pos_ff == POS_MAX, "oversize flag without saturation")

endmodule

[hw/rtl/crc_packet_checker_splitter.sv]
// Top level of the CRC packet checker/splitter: config registers and result queue.
// Depends on crcpcs_pkg, crcpcs_core and assert_macros.svh.
//
// Usage:
//   req_*  : one packet byte per request, req_tlast on the last byte of a packet.
//   rsp_*  : released bytes tagged with their role, then one status item
//            (rsp_tlast high) per packet. The two trailing CRC bytes are dropped.
//   csr_*  : register writes (0 start_offset, 1 min_length), only while idle.
// Latency: results of a request are written into a 4-entry queue at the edge
//   that accepts it and can be taken from the next cycle on. A byte comes out
//   with the request two bytes later in the same packet.
// Throughput: one request per cycle while req_tready is high. A request makes at
//   most two results; req_tready is high while the queue has room for two, and a
//   final byte's second result is absorbed by the following idle-result bytes.
// Reset: clears packet state, queue and registers (start_offset 0,
//   min_length 3). When the receiver stalls, the queue fills and req_tready
//   drops; nothing is lost.
`include "assert_macros.svh"

module crc_packet_checker_splitter #(
   parameter int MAX_PACKET_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // final_byte
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [10:8] status, rest zero
   output logic [2:0]  rsp_tuser,   // [2:0] role
   output logic        rsp_tlast,   // end_of_run
   // register writes
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);
   import crcpcs_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cfg_type            cfg_ff, cfg_in;
   core_out_type       core_out;
   item_type           q_ff [DEPTH];
   item_type           first_item, head_item;
   logic [PTR_W-1:0]   head_ff, head_in, tail_ff, tail_in, tail_next;
   logic [CNT_W-1:0]   count_ff, count_in, n_push;
   logic               fire, pop, wr0, wr1;

   assign fire      = req_tvalid && req_tready;
   assign req_tready = count_ff <= CNT_W'(DEPTH - 2);
   assign rsp_tvalid = count_ff != '0;
   assign pop       = rsp_tvalid && rsp_tready;

   crcpcs_core #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .fire       (fire),
      .data_byte  (req_tdata),
      .final_byte (req_tlast),
      .core_out   (core_out)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_START_OFFSET: cfg_in.start_offset = csr_wdata;
            CSR_MIN_LENGTH:   cfg_in.min_length   = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      wr0        = fire && (core_out.byte_valid || core_out.status_valid);
      wr1        = fire && core_out.byte_valid && core_out.status_valid;
      first_item = core_out.byte_valid ? core_out.byte_item : core_out.status_item;
      tail_next  = tail_ff + PTR_W'(1);
      n_push     = CNT_W'(wr0) + CNT_W'(wr1);
      tail_in    = tail_ff + PTR_W'(n_push);
      head_in    = pop ? head_ff + PTR_W'(1) : head_ff;
      count_in   = count_ff + n_push - CNT_W'(pop);
      head_item  = q_ff[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_offset <= START_OFFSET_RESET;
         cfg_ff.min_length   <= MIN_LENGTH_RESET;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         cfg_ff   <= cfg_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr0) begin
         q_ff[tail_ff] <= first_item;
      end
      if (wr1) begin
         q_ff[tail_next] <= core_out.status_item;
      end
   end

   assign rsp_tdata = {5'b0, head_item.status, head_item.out_byte};
   assign rsp_tuser = head_item.role;
   assign rsp_tlast = head_item.end_of_run;

   `ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(DEPTH), "result queue overflow")
   `ASSERT_IMPLY(a_status_tag, rsp_tvalid && rsp_tlast, rsp_tuser == ROLE_STATUS,
                 "end of run on a non-status item")
   `ASSERT_NEXT(a_final_out, fire && req_tlast, rsp_tvalid,
                "final byte accepted without a pending status item")

endmodule
